>>> design/multilevel_feedback_scheduler_unit_assert.svh
// assertion macros for the feedback scheduler
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/mfs_pkg.sv
// shared types and constants for the feedback scheduler
`timescale 1ns / 1ps
package mfs_pkg;
    localparam int MAX_PROCS_DEF = 8;
    localparam logic [3:0] QUANTUM_RESET = 4'd3;
    localparam int NUM_QUEUES = 5;

    typedef enum logic [2:0] {
        Q_HIGH    = 3'd0,
        Q_LOW     = 3'd1,
        Q_DISK    = 3'd2,
        Q_TAPE    = 3'd3,
        Q_PRINTER = 3'd4
    } queue_id_t;

    typedef enum logic [2:0] {
        EV_IDLE      = 3'd0,
        EV_RAN       = 3'd1,
        EV_FINISHED  = 3'd2,
        EV_PREEMPTED = 3'd3,
        EV_BLOCKED   = 3'd4,
        EV_CREATED   = 3'd5,
        EV_REJECTED  = 3'd6
    } event_t;

    localparam logic [1:0] KIND_DISK = 2'd1;
    localparam logic [1:0] KIND_TAPE = 2'd2;

    // one queue operation request from sequencer to queue unit
    typedef struct packed {
        logic      push;
        logic      pop;
        queue_id_t q;
    } qop_t;
endpackage

>>> design/multilevel_feedback_scheduler_unit.sv
// feedback scheduler top level: handshake, result register and quantum register
// throughput: one item at a time; the next is taken the cycle after the result leaves
// the device walk through the shared queue memory sets the tick length
// reset (asynchronous, active low) empties all queues and counters, quantum 3
`timescale 1ns / 1ps
module multilevel_feedback_scheduler_unit #(
    parameter int MAX_PROCS = mfs_pkg::MAX_PROCS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [5:0]  cpu_need,
    input  logic        io_request,
    input  logic [1:0]  io_kind,
    input  logic [3:0]  io_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [2:0]  proc_id,
    output logic [5:0]  cpu_remaining,
    output logic [15:0] clock_now,
    output logic        all_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    localparam int PW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    logic          busy, done, start;
    logic [2:0]    ev_w, pid_w;
    logic [5:0]    rem_w;
    logic [15:0]   clk_w;
    logic          ad_w;
    logic [3:0]    quantum_reg;
    mfs_pkg::qop_t op;
    logic [PW-1:0] push_pid, pop_pid;
    logic [CW-1:0] counts [mfs_pkg::NUM_QUEUES];

    assign in_stall  = busy || out_valid;
    assign start     = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= mfs_pkg::QUANTUM_RESET;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                quantum_reg <= cfg_data;
            end
            if (done)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            event_res     <= ev_w;
            proc_id       <= pid_w;
            cpu_remaining <= rem_w;
            clock_now     <= clk_w;
            all_done      <= ad_w;
        end
    end

    mfs_queues #(.MAX_PROCS(MAX_PROCS), .PW(PW), .CW(CW)) u_queues (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .push_pid (push_pid),
        .pop_pid  (pop_pid),
        .counts   (counts)
    );

    mfs_seq #(.MAX_PROCS(MAX_PROCS), .PW(PW), .CW(CW)) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .cpu_need      (cpu_need),
        .io_request    (io_request),
        .io_kind       (io_kind),
        .io_time       (io_time),
        .quantum       (quantum_reg),
        .busy          (busy),
        .done          (done),
        .event_res     (ev_w),
        .proc_id       (pid_w),
        .cpu_remaining (rem_w),
        .clock_now     (clk_w),
        .all_done      (ad_w),
        .op            (op),
        .push_pid      (push_pid),
        .pop_pid       (pop_pid),
        .counts        (counts)
    );
endmodule

>>> design/mfs_queues.sv
// five circular process queues sharing one memory, one push or pop per cycle
`timescale 1ns / 1ps
module mfs_queues #(
    parameter int MAX_PROCS = mfs_pkg::MAX_PROCS_DEF,
    parameter int PW = $clog2(MAX_PROCS),
    parameter int CW = $clog2(MAX_PROCS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mfs_pkg::qop_t         op,
    input  logic [PW-1:0]         push_pid,
    output logic [PW-1:0]         pop_pid,
    output logic [CW-1:0]         counts [mfs_pkg::NUM_QUEUES]
);
    localparam int AW = $clog2(mfs_pkg::NUM_QUEUES * MAX_PROCS);

    logic [PW-1:0] mem [mfs_pkg::NUM_QUEUES * MAX_PROCS];
    logic [PW-1:0] head_reg [mfs_pkg::NUM_QUEUES];
    logic [PW-1:0] tail_reg [mfs_pkg::NUM_QUEUES];
    logic [CW-1:0] count_reg [mfs_pkg::NUM_QUEUES];
    logic [AW-1:0] base;
    logic [PW-1:0] head_sel, tail_sel;
    logic [CW-1:0] count_sel;
    logic          do_push, do_pop;

    assign head_sel  = head_reg[op.q];
    assign tail_sel  = tail_reg[op.q];
    assign count_sel = count_reg[op.q];
    assign base      = AW'(op.q) * AW'(MAX_PROCS);
    assign do_push   = op.push && (count_sel < CW'(MAX_PROCS));
    assign do_pop    = op.pop && (count_sel != '0);

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] v);
        logic [PW:0] s;
        s = {1'b0, v} + 1'b1;
        wrap_inc = (s == (PW+1)'(MAX_PROCS)) ? '0 : s[PW-1:0];
    endfunction

    // pop data is registered, appears in the cycle after the pop request and holds until the next pop
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[base + AW'(tail_sel)] <= push_pid;
        end
        if (do_pop)
        begin
            pop_pid <= mem[base + AW'(head_sel)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mfs_pkg::NUM_QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (do_push)
            begin
                tail_reg[op.q]  <= wrap_inc(tail_sel);
                count_reg[op.q] <= count_sel + 1'b1;
            end
            else if (do_pop)
            begin
                head_reg[op.q]  <= wrap_inc(head_sel);
                count_reg[op.q] <= count_sel - 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < mfs_pkg::NUM_QUEUES; i++)
        begin
            counts[i] = count_reg[i];
        end
    end
endmodule

>>> design/mfs_seq.sv
// tick and create sequencer with per-process tables
`timescale 1ns / 1ps
`include "multilevel_feedback_scheduler_unit_assert.svh"
module mfs_seq #(
    parameter int MAX_PROCS = mfs_pkg::MAX_PROCS_DEF,
    parameter int PW = $clog2(MAX_PROCS),
    parameter int CW = $clog2(MAX_PROCS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          cmd,
    input  logic [5:0]    cpu_need,
    input  logic          io_request,
    input  logic [1:0]    io_kind,
    input  logic [3:0]    io_time,
    input  logic [3:0]    quantum,
    output logic          busy,
    output logic          done,
    output logic [2:0]    event_res,
    output logic [2:0]    proc_id,
    output logic [5:0]    cpu_remaining,
    output logic [15:0]   clock_now,
    output logic          all_done,
    output mfs_pkg::qop_t op,
    output logic [PW-1:0] push_pid,
    input  logic [PW-1:0] pop_pid,
    input  logic [CW-1:0] counts [mfs_pkg::NUM_QUEUES]
);
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CREATE = 10'b0000000010,
        S_DISP   = 10'b0000000100,
        S_DWAIT  = 10'b0000001000,
        S_CHARGE = 10'b0000010000,
        S_DEVPOP = 10'b0000100000,
        S_DEVUPD = 10'b0001000000,
        S_FINAL  = 10'b0010000000,
        S_OUT    = 10'b0100000000,
        S_NEXTQ  = 10'b1000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [5:0]    cpu_left [MAX_PROCS];
    logic [3:0]    io_left [MAX_PROCS];
    logic [PW-1:0] run_reg;
    logic          run_valid_reg;
    logic [3:0]    slice_reg;
    logic [15:0]   clock_reg;
    logic [CW-1:0] created_reg, finished_reg;
    logic          ioreq_reg;
    logic [1:0]    kind_reg;
    logic [3:0]    iot_reg;
    logic [5:0]    need_reg;
    mfs_pkg::queue_id_t dev_reg;
    logic [CW-1:0] left_reg;
    logic [2:0]    ev_reg;
    logic [5:0]    rem_reg;
    logic [2:0]    pid_out_reg;
    logic          dispatched_reg;
    logic [3:0]    q_eff;
    logic [3:0]    io_dec;
    logic [5:0]    cpu_run;
    mfs_pkg::queue_id_t blk_q;

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_OUT);
    assign event_res     = ev_reg;
    assign proc_id       = pid_out_reg;
    assign cpu_remaining = rem_reg;
    assign clock_now     = clock_reg;
    assign all_done      = (created_reg == finished_reg);
    assign q_eff         = (quantum == 4'd0) ? 4'd1 : quantum;
    assign io_dec        = (io_left[pop_pid] != 4'd0) ? io_left[pop_pid] - 4'd1 : 4'd0;
    assign cpu_run       = cpu_left[run_reg];
    assign blk_q         = (kind_reg == mfs_pkg::KIND_DISK) ? mfs_pkg::Q_DISK :
                           (kind_reg == mfs_pkg::KIND_TAPE) ? mfs_pkg::Q_TAPE :
                           mfs_pkg::Q_PRINTER;

    // queue operations issued per state
    always_comb
    begin
        op       = '{push: 1'b0, pop: 1'b0, q: mfs_pkg::Q_HIGH};
        push_pid = run_reg;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = cmd ? S_CREATE : S_DISP;
            S_CREATE:
            begin
                if (created_reg < CW'(MAX_PROCS))
                begin
                    op.push  = 1'b1;
                    push_pid = created_reg[PW-1:0];
                end
                state_next = S_OUT;
            end
            S_DISP:
            begin
                if (!run_valid_reg && counts[mfs_pkg::Q_HIGH] != '0)
                begin
                    op.pop = 1'b1;
                    op.q   = mfs_pkg::Q_HIGH;
                end
                else if (!run_valid_reg && counts[mfs_pkg::Q_LOW] != '0)
                begin
                    op.pop = 1'b1;
                    op.q   = mfs_pkg::Q_LOW;
                end
                state_next = S_DWAIT;
            end
            S_DWAIT:  state_next = S_CHARGE;
            S_CHARGE: state_next = S_NEXTQ;
            S_NEXTQ:
            begin
                if (left_reg != '0)
                begin
                    op.pop = 1'b1;
                    op.q   = dev_reg;
                    state_next = S_DEVPOP;
                end
                else if (dev_reg == mfs_pkg::Q_PRINTER)
                begin
                    state_next = S_FINAL;
                end
            end
            S_DEVPOP: state_next = S_DEVUPD;
            S_DEVUPD:
            begin
                op.push  = 1'b1;
                push_pid = pop_pid;
                op.q     = (io_dec != 4'd0) ? dev_reg :
                           (dev_reg == mfs_pkg::Q_DISK) ? mfs_pkg::Q_LOW : mfs_pkg::Q_HIGH;
                state_next = S_NEXTQ;
            end
            S_FINAL:
            begin
                if (run_valid_reg && cpu_run != 6'd0)
                begin
                    if (ioreq_reg)
                    begin
                        op.push = 1'b1;
                        op.q    = blk_q;
                    end
                    else if (slice_reg >= q_eff)
                    begin
                        op.push = 1'b1;
                        op.q    = mfs_pkg::Q_LOW;
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // per-process tables, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CREATE && created_reg < CW'(MAX_PROCS))
        begin
            cpu_left[created_reg[PW-1:0]] <= need_reg;
            io_left[created_reg[PW-1:0]]  <= 4'd0;
        end
        if (state_reg == S_CHARGE && run_valid_reg && cpu_run != 6'd0)
        begin
            cpu_left[run_reg] <= cpu_run - 6'd1;
        end
        if (state_reg == S_DEVUPD)
        begin
            io_left[pop_pid] <= io_dec;
        end
        if (state_reg == S_FINAL && run_valid_reg && cpu_run != 6'd0 && ioreq_reg)
        begin
            io_left[run_reg] <= iot_reg;
        end
        if (state_reg == S_IDLE && start)
        begin
            need_reg  <= cpu_need;
            ioreq_reg <= io_request;
            kind_reg  <= io_kind;
            iot_reg   <= io_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_reg       <= '0;
            run_valid_reg <= 1'b0;
            slice_reg     <= '0;
            clock_reg     <= '0;
            created_reg   <= '0;
            finished_reg  <= '0;
            dev_reg       <= mfs_pkg::Q_DISK;
            left_reg      <= '0;
            ev_reg        <= mfs_pkg::EV_IDLE;
            rem_reg       <= '0;
            pid_out_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    ev_reg      <= mfs_pkg::EV_IDLE;
                    rem_reg     <= '0;
                    pid_out_reg <= '0;
                end
                S_CREATE:
                begin
                    if (created_reg < CW'(MAX_PROCS))
                    begin
                        pid_out_reg <= 3'(created_reg);
                        rem_reg     <= need_reg;
                        ev_reg      <= mfs_pkg::EV_CREATED;
                        created_reg <= created_reg + 1'b1;
                    end
                    else
                    begin
                        ev_reg <= mfs_pkg::EV_REJECTED;
                    end
                end
                S_DISP:
                begin
                    if (!run_valid_reg && (counts[mfs_pkg::Q_HIGH] != '0 ||
                                           counts[mfs_pkg::Q_LOW] != '0))
                    begin
                        run_valid_reg <= 1'b1;
                        slice_reg     <= '0;
                    end
                    clock_reg <= clock_reg + 16'd1;
                end
                S_CHARGE:
                begin
                    if (run_valid_reg && cpu_run != 6'd0 && slice_reg != 4'd15)
                    begin
                        slice_reg <= slice_reg + 4'd1;
                    end
                    dev_reg  <= mfs_pkg::Q_DISK;
                    left_reg <= counts[mfs_pkg::Q_DISK];
                end
                S_NEXTQ:
                begin
                    if (left_reg != '0)
                    begin
                        left_reg <= left_reg - 1'b1;
                    end
                    else if (dev_reg == mfs_pkg::Q_DISK)
                    begin
                        dev_reg  <= mfs_pkg::Q_TAPE;
                        left_reg <= counts[mfs_pkg::Q_TAPE];
                    end
                    else if (dev_reg == mfs_pkg::Q_TAPE)
                    begin
                        dev_reg  <= mfs_pkg::Q_PRINTER;
                        left_reg <= counts[mfs_pkg::Q_PRINTER];
                    end
                end
                S_FINAL:
                begin
                    if (run_valid_reg)
                    begin
                        pid_out_reg <= 3'(run_reg);
                        rem_reg     <= cpu_run;
                        if (cpu_run == 6'd0)
                        begin
                            finished_reg  <= finished_reg + 1'b1;
                            run_valid_reg <= 1'b0;
                            ev_reg        <= mfs_pkg::EV_FINISHED;
                        end
                        else if (ioreq_reg)
                        begin
                            run_valid_reg <= 1'b0;
                            ev_reg        <= mfs_pkg::EV_BLOCKED;
                        end
                        else if (slice_reg >= q_eff)
                        begin
                            run_valid_reg <= 1'b0;
                            ev_reg        <= mfs_pkg::EV_PREEMPTED;
                        end
                        else
                        begin
                            ev_reg <= mfs_pkg::EV_RAN;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            // capture dispatched id in the cycle after the pop
            if (state_reg == S_DWAIT && dispatched_reg)
            begin
                run_reg <= pop_pid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dispatched_reg <= 1'b0;
        end
        else
        begin
            dispatched_reg <= (state_reg == S_DISP) && op.pop;
        end
    end

    `MFS_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start did not leave idle")
    `MFS_ASSERT_IMP(a_fin_le_cr, clk, rst_n, 1'b1, finished_reg <= created_reg, "finished > created")
    `MFS_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy, "result shown while idle")
    `MFS_ASSERT_NEXT(a_clk_step, clk, rst_n, state_reg == S_DISP, clock_reg == $past(clock_reg) + 16'd1, "clock")
endmodule

>>> bench/tb_multilevel_feedback_scheduler_unit.sv
// self-checking bench for the multilevel feedback scheduler top level
`timescale 1ns / 1ps
module tb_multilevel_feedback_scheduler_unit;
    localparam int NPROC = 8;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        mfs_pkg::event_t ev;
        logic [2:0]  pid;
        logic [5:0]  rem;
        logic [15:0] now;
        logic        done;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [5:0]  cpu_need;
    logic        io_request;
    logic [1:0]  io_kind;
    logic [3:0]  io_time;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  event_res;
    logic [2:0]  proc_id;
    logic [5:0]  cpu_remaining;
    logic [15:0] clock_now;
    logic        all_done;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    multilevel_feedback_scheduler_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .cpu_need      (cpu_need),
        .io_request    (io_request),
        .io_kind       (io_kind),
        .io_time       (io_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .proc_id       (proc_id),
        .cpu_remaining (cpu_remaining),
        .clock_now     (clock_now),
        .all_done      (all_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // scheduler shadow state
    logic [5:0]  sh_cpu_left [NPROC];
    logic [3:0]  sh_io_left [NPROC];
    logic [2:0]  sh_queue [mfs_pkg::NUM_QUEUES][$];
    logic [2:0]  sh_running;
    logic        sh_running_valid;
    logic [3:0]  sh_slice;
    logic [15:0] sh_clock;
    logic [3:0]  sh_created;
    logic [3:0]  sh_finished;
    logic [3:0]  sh_quantum;

    sched_result_t pending_results[$];
    int  mismatches;
    int  checked;
    int  cycles;
    int  event_hist [8];
    bit  gaps_on;
    int  hold_cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ticks of every blocked process on one device, completions rejoin a ready queue
    function automatic void count_down_device(input int q);
        int n;
        logic [2:0] p;
        n = sh_queue[q].size();
        for (int i = 0; i < n; i++)
        begin
            p = sh_queue[q].pop_front();
            if (sh_io_left[p] != 4'd0)
                sh_io_left[p] = sh_io_left[p] - 4'd1;
            if (sh_io_left[p] == 4'd0)
            begin
                if (q == int'(mfs_pkg::Q_DISK))
                    sh_queue[mfs_pkg::Q_LOW].push_back(p);
                else
                    sh_queue[mfs_pkg::Q_HIGH].push_back(p);
            end
            else
                sh_queue[q].push_back(p);
        end
    endfunction

    function automatic sched_result_t schedule_step(input logic c, input logic [5:0] need,
                                                    input logic req, input logic [1:0] kind,
                                                    input logic [3:0] dur);
        sched_result_t r;
        logic [3:0] quantum;
        r.ev = mfs_pkg::EV_IDLE;
        r.pid = '0;
        r.rem = '0;
        if (c)
        begin
            if (sh_created < 4'(NPROC))
            begin
                r.pid = sh_created[2:0];
                sh_cpu_left[r.pid] = need;
                sh_io_left[r.pid] = '0;
                sh_queue[mfs_pkg::Q_HIGH].push_back(r.pid);
                sh_created = sh_created + 4'd1;
                r.ev = mfs_pkg::EV_CREATED;
                r.rem = need;
            end
            else
                r.ev = mfs_pkg::EV_REJECTED;
        end
        else
        begin
            quantum = (sh_quantum == 4'd0) ? 4'd1 : sh_quantum;
            if (!sh_running_valid)
            begin
                if (sh_queue[mfs_pkg::Q_HIGH].size() != 0)
                begin
                    sh_running = sh_queue[mfs_pkg::Q_HIGH].pop_front();
                    sh_running_valid = 1'b1;
                    sh_slice = '0;
                end
                else if (sh_queue[mfs_pkg::Q_LOW].size() != 0)
                begin
                    sh_running = sh_queue[mfs_pkg::Q_LOW].pop_front();
                    sh_running_valid = 1'b1;
                    sh_slice = '0;
                end
            end
            sh_clock = sh_clock + 16'd1;
            if (sh_running_valid)
            begin
                r.pid = sh_running;
                if (sh_cpu_left[r.pid] != 6'd0)
                begin
                    sh_cpu_left[r.pid] = sh_cpu_left[r.pid] - 6'd1;
                    if (sh_slice < 4'd15)
                        sh_slice = sh_slice + 4'd1;
                end
            end
            count_down_device(int'(mfs_pkg::Q_DISK));
            count_down_device(int'(mfs_pkg::Q_TAPE));
            count_down_device(int'(mfs_pkg::Q_PRINTER));
            if (sh_running_valid)
            begin
                r.rem = sh_cpu_left[r.pid];
                sh_running_valid = 1'b0;
                if (r.rem == 6'd0)
                begin
                    sh_finished = sh_finished + 4'd1;
                    r.ev = mfs_pkg::EV_FINISHED;
                end
                else if (req)
                begin
                    sh_io_left[r.pid] = dur;
                    // kind zero lands on the printer
                    if (kind == mfs_pkg::KIND_DISK)
                        sh_queue[mfs_pkg::Q_DISK].push_back(r.pid);
                    else if (kind == mfs_pkg::KIND_TAPE)
                        sh_queue[mfs_pkg::Q_TAPE].push_back(r.pid);
                    else
                        sh_queue[mfs_pkg::Q_PRINTER].push_back(r.pid);
                    r.ev = mfs_pkg::EV_BLOCKED;
                end
                else if (sh_slice >= quantum)
                begin
                    sh_queue[mfs_pkg::Q_LOW].push_back(r.pid);
                    r.ev = mfs_pkg::EV_PREEMPTED;
                end
                else
                begin
                    sh_running_valid = 1'b1;
                    r.ev = mfs_pkg::EV_RAN;
                end
            end
        end
        r.now = sh_clock;
        r.done = (sh_finished == sh_created);
        return r;
    endfunction

    // one input transaction; valid stays high if the next one follows without a gap
    task automatic send_item(input logic c, input logic [5:0] need, input logic req,
                             input logic [1:0] kind, input logic [3:0] dur);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        cmd = c;
        cpu_need = need;
        io_request = req;
        io_kind = kind;
        io_time = dur;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(schedule_step(c, need, req, kind, dur));
    endtask

    task automatic send_tick(input logic req, input logic [1:0] kind, input logic [3:0] dur);
        send_item(1'b0, 6'($urandom()), req, kind, dur);
    endtask

    task automatic send_random_item();
        logic c;
        c = ($urandom_range(0, 59) == 0);
        if (c)
            send_item(1'b1, ($urandom_range(0, 19) == 0) ? 6'd0 : 6'($urandom_range(1, 63)),
                      1'($urandom()), 2'($urandom()), 4'($urandom()));
        else
            send_tick($urandom_range(0, 3) == 0,
                      ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3)),
                      4'($urandom()));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_quantum(input logic [3:0] q);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data = q;
        do
            @(posedge clk);
        while (!cfg_ready);
        sh_quantum = q;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // receiver: random stall before each result, or one long hold when requested
    initial
    begin
        int w;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                w = hold_cycles;
                hold_cycles = 0;
            end
            else
                w = gaps_on ? $urandom_range(0, 15) : 0;
            if (w > 0)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: event %0d proc %0d", event_res,
                             proc_id);
            end
            else
            begin
                sched_result_t e;
                e = pending_results.pop_front();
                checked++;
                event_hist[e.ev]++;
                if (event_res !== e.ev || proc_id !== e.pid || cpu_remaining !== e.rem ||
                    clock_now !== e.now || all_done !== e.done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp ev %0d id %0d rem %0d clk %0d done %0d,",
                                  " got ev %0d id %0d rem %0d clk %0d done %0d"},
                                 e.ev, e.pid, e.rem, e.now, e.done, event_res, proc_id,
                                 cpu_remaining, clock_now, all_done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_multilevel_feedback_scheduler_unit: errors");
            $finish;
        end
    end

    task automatic test_idle_after_reset();
        send_tick(1'b0, 2'd1, 4'd1);
        send_tick(1'b1, 2'd3, 4'd15);
        send_tick(1'b0, 2'd0, 4'd0);
    endtask

    task automatic test_directed();
        send_item(1'b1, 6'd0, 1'b0, 2'd0, 4'd0);
        send_item(1'b1, 6'd63, 1'b1, 2'd3, 4'd15);
        send_item(1'b1, 6'd2, 1'b0, 2'd1, 4'd1);
        send_tick(1'b1, 2'd1, 4'd3);   // zero-need process finishes, request ignored
        send_tick(1'b0, 2'd1, 4'd1);
        send_tick(1'b1, 2'd1, 4'd2);   // long process to disk
        send_tick(1'b1, 2'd2, 4'd0);   // two-tick process blocks on tape after its first tick
        send_tick(1'b0, 2'd2, 4'd0);
        send_tick(1'b0, 2'd2, 4'd0);
        send_tick(1'b1, 2'd2, 4'd0);   // tape with zero time
        send_tick(1'b0, 2'd3, 4'd15);
        send_tick(1'b1, 2'd0, 4'd1);   // kind zero
        send_tick(1'b0, 2'd3, 4'd1);
        send_tick(1'b1, 2'd3, 4'd4);
        for (int i = 0; i < 8; i++)
            send_tick(1'b0, 2'd1, 4'd1);
    endtask

    task automatic test_quantum_phase(input logic [3:0] q, input int n);
        write_quantum(q);
        for (int i = 0; i < n; i++)
        begin
            gaps_on = ((i / 60) % 3) != 2;
            send_random_item();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 40; i++)
            send_random_item();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < 10; i++)
            send_item(1'b1, 6'($urandom_range(1, 63)), 1'b0, 2'd1, 4'd1);
        for (int i = 0; i < 60; i++)
            send_random_item();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = 1'b0;
        cpu_need = '0;
        io_request = 1'b0;
        io_kind = '0;
        io_time = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        gaps_on = 1'b1;
        hold_cycles = 0;
        mismatches = 0;
        checked = 0;
        cycles = 0;
        foreach (event_hist[i])
            event_hist[i] = 0;
        foreach (sh_cpu_left[i])
        begin
            sh_cpu_left[i] = '0;
            sh_io_left[i] = '0;
        end
        sh_running = '0;
        sh_running_valid = 1'b0;
        sh_slice = '0;
        sh_clock = '0;
        sh_created = '0;
        sh_finished = '0;
        sh_quantum = mfs_pkg::QUANTUM_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_after_reset();
        test_directed();
        test_quantum_phase(4'd1, 300);
        test_backpressure();
        test_quantum_phase(4'd15, 300);
        test_quantum_phase(4'd0, 300);
        test_table_full();
        test_quantum_phase(4'($urandom_range(2, 14)), 300);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d results checked: idle %0d ran %0d finished %0d preempted %0d",
                 checked, event_hist[mfs_pkg::EV_IDLE], event_hist[mfs_pkg::EV_RAN],
                 event_hist[mfs_pkg::EV_FINISHED], event_hist[mfs_pkg::EV_PREEMPTED]);
        $display("blocked %0d created %0d rejected %0d, quanta 3, 1, 15, 0 and one random",
                 event_hist[mfs_pkg::EV_BLOCKED], event_hist[mfs_pkg::EV_CREATED],
                 event_hist[mfs_pkg::EV_REJECTED]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_multilevel_feedback_scheduler_unit: clean");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     pending_results.size());
            $display("tb_multilevel_feedback_scheduler_unit: errors");
        end
        $finish;
    end
endmodule
